/* rtl/bps_pkg.sv */
// bps_pkg: shared types, reset values and saturation helpers for the ball physics step block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

  localparam int FRAC_BITS_DEF = 8;

  // register reset values, 8 fraction bits
  localparam logic [19:0] GRAVITY_RST      = 20'd250880;
  localparam logic [19:0] LAUNCH_SPEED_RST = 20'd153600;
  localparam logic [17:0] RIGHT_WALL_RST   = 18'd204800;
  localparam logic [17:0] FLOOR_LINE_RST   = 18'd153600;
  localparam logic [13:0] BALL_RADIUS_RST  = 14'd2048;
  localparam logic [17:0] START_X_RST      = 18'd102400;
  localparam logic [17:0] START_Y_RST      = 18'd12800;

  // 1.0 in q1.14
  localparam logic signed [15:0] UNIT_ONE = 16'sd16384;

  localparam logic signed [23:0] VEL_MAX = 24'sh7fffff;
  localparam logic signed [23:0] VEL_MIN = -24'sh800000;
  localparam logic signed [18:0] POS_MAX = 19'sh3ffff;
  localparam logic signed [18:0] POS_MIN = -19'sh40000;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_AIM     = 3'd1,
    OP_LAUNCH  = 3'd2,
    OP_REBOUND = 3'd3,
    OP_RESTART = 3'd4
  } bps_op_t;

  typedef enum logic [2:0] {
    CFG_GRAVITY      = 3'd0,
    CFG_LAUNCH_SPEED = 3'd1,
    CFG_RIGHT_WALL   = 3'd2,
    CFG_FLOOR_LINE   = 3'd3,
    CFG_BALL_RADIUS  = 3'd4,
    CFG_START_X      = 3'd5,
    CFG_START_Y      = 3'd6
  } bps_cfg_t;

  function automatic logic signed [23:0] sat_vel(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > 64'(VEL_MAX)) r = VEL_MAX;
    else if (v < 64'(VEL_MIN)) r = VEL_MIN;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic signed [18:0] sat_pos(input logic signed [63:0] v);
    logic signed [18:0] r;
    if (v > 64'(POS_MAX)) r = POS_MAX;
    else if (v < 64'(POS_MIN)) r = POS_MIN;
    else r = v[18:0];
    return r;
  endfunction

  function automatic logic signed [23:0] neg_vel(input logic signed [23:0] v);
    logic signed [23:0] r;
    if (v == VEL_MIN) r = VEL_MAX;
    else r = -v;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/ball_physics_step.sv */
// a finished result waits in the done state until the output is free
// one word at a time: in_tready is high only when the sequencer is idle
// aim and rebound time is set by the bit-pair square root loop and the
//   one-bit-per-cycle divider, all products go through one shared multiplier
// rst_n (synchronous, low) loads register defaults and puts the ball at its start
`timescale 1ns / 1ps
`default_nettype none

module ball_physics_step
  import bps_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // delta_time[15:0], mouse_x[27:16], mouse_y[39:28], peg_x[58:40], peg_y[77:59], zero pad
  input  wire logic [79:0] in_tdata,
  // opcode[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // pos_x[18:0], pos_y[37:19], speed_x[61:38], speed_y[85:62], in_flight[86],
  // has_dropped[87]
  output logic [87:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [19:0] cfg_wdata
);

  localparam int DW   = (((12 + FRAC_BITS) > 19) ? (12 + FRAC_BITS) : 19) + 1;
  localparam int MW   = ((DW > 24) ? DW : 24) + 1;
  localparam int PW   = 2 * MW;
  localparam int SQW  = 2 * DW;
  localparam int ACCW = (SQW > 57) ? SQW : 57;
  localparam int CW   = $clog2(DW);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_T_GRAV, S_T_GRAVW, S_T_VX, S_T_VXW, S_T_VY, S_T_VYW, S_T_WALL,
    S_SQ_X, S_SQ_Y, S_SQ_SUM, S_SQRT, S_DIV_INIT, S_DIV, S_DIV_END, S_UNIT_END,
    S_DOT_X, S_DOT_Y, S_DOT_SUM, S_RX_LO, S_RX_HI, S_RX_UPD, S_RY_LO, S_RY_HI, S_RY_UPD,
    S_L_X, S_L_Y, S_L_YW, S_DONE
  } state_t;

  state_t state_r;

  // architectural state
  logic signed [18:0] ball_x_r, ball_y_r;
  logic signed [23:0] vel_x_r, vel_y_r;
  logic signed [15:0] aim_x_r, aim_y_r;
  logic               launched_r, fallen_r;

  // configuration
  logic [19:0] grav_r, lspd_r;
  logic [17:0] rwall_r, floor_r, stx_r, sty_r;
  logic [13:0] rad_r;

  // captured word
  logic [2:0]         op_r;
  logic [15:0]        dt_r;
  logic signed [11:0] mx_r, my_r;
  logic signed [18:0] pgx_r, pgy_r;

  // work registers
  logic signed [DW-1:0]   dx_r, dy_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [ACCW-1:0] acc_r;
  logic [SQW-1:0]         sqn_r, sqres_r, sqbit_r;
  logic [DW:0]            len_r;
  logic [DW+1:0]          rem_r;
  logic [14:0]            quo_r;
  logic                   lsb_r, neg_r, comp_r;
  logic signed [15:0]     nx_r, ny_r;
  logic signed [39:0]     dot_r;
  logic [CW-1:0]          cnt_r;

  logic        out_tvalid_r;
  logic [87:0] out_tdata_r;

  // shared multiplier operands
  logic signed [MW-1:0] mul_a, mul_b;

  logic signed [19:0] dot_hi;
  logic signed [20:0] dot_lo;
  assign dot_hi = dot_r[39:20];
  assign dot_lo = {1'b0, dot_r[19:0]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_T_GRAV: begin
        mul_a = MW'({1'b0, grav_r});
        mul_b = MW'({1'b0, dt_r});
      end
      S_T_VX: begin
        mul_a = MW'(vel_x_r);
        mul_b = MW'({1'b0, dt_r});
      end
      S_T_VY: begin
        mul_a = MW'(vel_y_r);
        mul_b = MW'({1'b0, dt_r});
      end
      S_SQ_X: begin
        mul_a = MW'(dx_r);
        mul_b = MW'(dx_r);
      end
      S_SQ_Y: begin
        mul_a = MW'(dy_r);
        mul_b = MW'(dy_r);
      end
      S_DOT_X: begin
        mul_a = MW'(vel_x_r);
        mul_b = MW'(nx_r);
      end
      S_DOT_Y: begin
        mul_a = MW'(vel_y_r);
        mul_b = MW'(ny_r);
      end
      S_RX_LO: begin
        mul_a = MW'(dot_lo);
        mul_b = MW'(nx_r);
      end
      S_RX_HI: begin
        mul_a = MW'(dot_hi);
        mul_b = MW'(nx_r);
      end
      S_RY_LO: begin
        mul_a = MW'(dot_lo);
        mul_b = MW'(ny_r);
      end
      S_RY_HI: begin
        mul_a = MW'(dot_hi);
        mul_b = MW'(ny_r);
      end
      S_L_X: begin
        mul_a = MW'(aim_x_r);
        mul_b = MW'({1'b0, lspd_r});
      end
      S_L_Y: begin
        mul_a = MW'(aim_y_r);
        mul_b = MW'({1'b0, lspd_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // event operands in DW-bit signed form
  logic signed [DW-1:0] px_s, py_s, bx_s, by_s, gx_s, gy_s;
  logic [DW-1:0]        abs_dx, abs_dy;
  assign px_s   = DW'(mx_r) <<< FRAC_BITS;
  assign py_s   = DW'(my_r) <<< FRAC_BITS;
  assign bx_s   = DW'(ball_x_r);
  assign by_s   = DW'(ball_y_r);
  assign gx_s   = DW'(pgx_r);
  assign gy_s   = DW'(pgy_r);
  assign abs_dx = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
  assign abs_dy = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);

  // square root step
  logic [SQW-1:0] sq_trial;
  assign sq_trial = sqres_r + sqbit_r;

  // divider step
  logic [DW+1:0] div_t;
  logic          div_ge;
  assign div_t  = {rem_r[DW:0], ((cnt_r == '0) ? lsb_r : 1'b0)};
  assign div_ge = div_t >= {1'b0, len_r};

  logic [14:0]        quo_c;
  logic signed [15:0] unit_v;
  assign quo_c  = (quo_r > 15'(UNIT_ONE)) ? 15'(UNIT_ONE) : quo_r;
  assign unit_v = neg_r ? -$signed({1'b0, quo_c}) : $signed({1'b0, quo_c});

  // rebound correction term
  logic signed [ACCW-1:0] refl_sum, refl_term;
  assign refl_sum  = acc_r + (ACCW'(prod_r) <<< 20);
  assign refl_term = refl_sum >>> 27;

  // wall and floor checks, left wall first
  logic               hit_l, hit_r, hit_f;
  logic signed [18:0] wx_a, wx_b;
  logic signed [23:0] wv_a, wv_b;
  always_comb begin
    hit_l = $signed({ball_x_r[18], ball_x_r}) < $signed({6'b0, rad_r});
    wx_a  = hit_l ? $signed({5'b0, rad_r}) : ball_x_r;
    wv_a  = hit_l ? neg_vel(vel_x_r) : vel_x_r;
    hit_r = ($signed({wx_a[18], wx_a[18], wx_a}) + $signed({7'b0, rad_r}))
            > $signed({3'b0, rwall_r});
    wx_b  = hit_r ? ($signed({1'b0, rwall_r}) - $signed({5'b0, rad_r})) : wx_a;
    wv_b  = hit_r ? neg_vel(wv_a) : wv_a;
    hit_f = ($signed({ball_y_r[18], ball_y_r[18], ball_y_r}) + $signed({7'b0, rad_r}))
            > $signed({3'b0, floor_r});
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      grav_r       <= GRAVITY_RST;
      lspd_r       <= LAUNCH_SPEED_RST;
      rwall_r      <= RIGHT_WALL_RST;
      floor_r      <= FLOOR_LINE_RST;
      rad_r        <= BALL_RADIUS_RST;
      stx_r        <= START_X_RST;
      sty_r        <= START_Y_RST;
      ball_x_r     <= $signed({1'b0, START_X_RST});
      ball_y_r     <= $signed({1'b0, START_Y_RST});
      vel_x_r      <= '0;
      vel_y_r      <= '0;
      aim_x_r      <= '0;
      aim_y_r      <= UNIT_ONE;
      launched_r   <= 1'b0;
      fallen_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_GRAVITY:      grav_r  <= cfg_wdata;
          CFG_LAUNCH_SPEED: lspd_r  <= cfg_wdata;
          CFG_RIGHT_WALL:   rwall_r <= cfg_wdata[17:0];
          CFG_FLOOR_LINE:   floor_r <= cfg_wdata[17:0];
          CFG_BALL_RADIUS:  rad_r   <= cfg_wdata[13:0];
          CFG_START_X:      stx_r   <= cfg_wdata[17:0];
          CFG_START_Y:      sty_r   <= cfg_wdata[17:0];
          default: ;
        endcase
      end

      // the done state always leaves a word valid, so it owns the flag there
      if (out_tready && (state_r != S_DONE)) out_tvalid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tuser;
            dt_r    <= in_tdata[15:0];
            mx_r    <= in_tdata[27:16];
            my_r    <= in_tdata[39:28];
            pgx_r   <= in_tdata[58:40];
            pgy_r   <= in_tdata[77:59];
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (op_r)
            OP_TICK:   state_r <= launched_r ? S_T_GRAV : S_DONE;
            OP_AIM: begin
              dx_r    <= px_s - bx_s;
              dy_r    <= py_s - by_s;
              state_r <= (py_s > by_s) ? S_SQ_X : S_DONE;
            end
            OP_LAUNCH: state_r <= launched_r ? S_DONE : S_L_X;
            OP_REBOUND: begin
              dx_r    <= bx_s - gx_s;
              dy_r    <= by_s - gy_s;
              state_r <= S_SQ_X;
            end
            OP_RESTART: begin
              ball_x_r   <= $signed({1'b0, stx_r});
              ball_y_r   <= $signed({1'b0, sty_r});
              vel_x_r    <= '0;
              vel_y_r    <= '0;
              launched_r <= 1'b0;
              fallen_r   <= 1'b0;
              state_r    <= S_DONE;
            end
            default: state_r <= S_DONE;
          endcase
        end

        // tick
        S_T_GRAV:  state_r <= S_T_GRAVW;
        S_T_GRAVW: begin
          vel_y_r <= sat_vel(64'(vel_y_r) + 64'(prod_r >>> 16));
          state_r <= S_T_VX;
        end
        S_T_VX:    state_r <= S_T_VXW;
        S_T_VXW: begin
          ball_x_r <= sat_pos(64'(ball_x_r) + 64'(prod_r >>> 16));
          state_r  <= S_T_VY;
        end
        S_T_VY:    state_r <= S_T_VYW;
        S_T_VYW: begin
          ball_y_r <= sat_pos(64'(ball_y_r) + 64'(prod_r >>> 16));
          state_r  <= S_T_WALL;
        end
        S_T_WALL: begin
          ball_x_r <= wx_b;
          vel_x_r  <= wv_b;
          if (hit_f) fallen_r <= 1'b1;
          state_r  <= S_DONE;
        end

        // length of the difference vector
        S_SQ_X: state_r <= S_SQ_Y;
        S_SQ_Y: begin
          acc_r   <= ACCW'(prod_r);
          state_r <= S_SQ_SUM;
        end
        S_SQ_SUM: begin
          sqn_r   <= SQW'(acc_r + ACCW'(prod_r));
          sqres_r <= '0;
          sqbit_r <= SQW'(1) << (SQW - 2);
          cnt_r   <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (sqn_r >= sq_trial) begin
            sqn_r   <= sqn_r - sq_trial;
            sqres_r <= (sqres_r >> 1) + sqbit_r;
          end else begin
            sqres_r <= sqres_r >> 1;
          end
          sqbit_r <= sqbit_r >> 2;
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == CW'(DW - 1)) state_r <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          len_r <= sqres_r[DW:0];
          if (sqres_r[DW:0] == '0) begin
            if (op_r == OP_REBOUND) begin
              nx_r    <= UNIT_ONE;
              ny_r    <= '0;
              state_r <= S_DOT_X;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            rem_r   <= (DW + 2)'(abs_dx >> 1);
            lsb_r   <= abs_dx[0];
            neg_r   <= dx_r[DW-1];
            quo_r   <= '0;
            cnt_r   <= '0;
            comp_r  <= 1'b0;
            state_r <= S_DIV;
          end
        end
        // one quotient bit a cycle, quotient stays below 2.0 in q1.14
        S_DIV: begin
          rem_r   <= div_ge ? (div_t - {1'b0, len_r}) : div_t;
          quo_r   <= {quo_r[13:0], div_ge};
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == CW'(14)) state_r <= S_DIV_END;
        end
        S_DIV_END: begin
          if (!comp_r) begin
            nx_r    <= unit_v;
            rem_r   <= (DW + 2)'(abs_dy >> 1);
            lsb_r   <= abs_dy[0];
            neg_r   <= dy_r[DW-1];
            quo_r   <= '0;
            cnt_r   <= '0;
            comp_r  <= 1'b1;
            state_r <= S_DIV;
          end else begin
            ny_r    <= unit_v;
            state_r <= S_UNIT_END;
          end
        end
        S_UNIT_END: begin
          if (op_r == OP_REBOUND) begin
            state_r <= S_DOT_X;
          end else begin
            aim_x_r <= nx_r;
            aim_y_r <= ny_r;
            state_r <= S_DONE;
          end
        end

        // reflection about the normal
        S_DOT_X: state_r <= S_DOT_Y;
        S_DOT_Y: begin
          acc_r   <= ACCW'(prod_r);
          state_r <= S_DOT_SUM;
        end
        S_DOT_SUM: begin
          dot_r   <= 40'(acc_r + ACCW'(prod_r));
          state_r <= S_RX_LO;
        end
        S_RX_LO: state_r <= S_RX_HI;
        S_RX_HI: begin
          acc_r   <= ACCW'(prod_r);
          state_r <= S_RX_UPD;
        end
        S_RX_UPD: begin
          vel_x_r <= sat_vel(64'(vel_x_r) - 64'(refl_term));
          state_r <= S_RY_LO;
        end
        S_RY_LO: state_r <= S_RY_HI;
        S_RY_HI: begin
          acc_r   <= ACCW'(prod_r);
          state_r <= S_RY_UPD;
        end
        S_RY_UPD: begin
          vel_y_r <= sat_vel(64'(vel_y_r) - 64'(refl_term));
          state_r <= S_DONE;
        end

        // launch
        S_L_X: state_r <= S_L_Y;
        S_L_Y: begin
          vel_x_r <= sat_vel(64'(prod_r >>> 14));
          state_r <= S_L_YW;
        end
        S_L_YW: begin
          vel_y_r    <= sat_vel(64'(prod_r >>> 14));
          launched_r <= 1'b1;
          state_r    <= S_DONE;
        end

        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {fallen_r, launched_r, vel_y_r, vel_x_r, ball_y_r, ball_x_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_aim_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    aim_x_r <= UNIT_ONE && aim_x_r >= -UNIT_ONE && aim_y_r <= UNIT_ONE && aim_y_r >= -UNIT_ONE)
    else $error("aim vector component out of range");

  a_launch_only_by_op: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(launched_r) |-> $past(op_r) == OP_LAUNCH)
    else $error("launched flag set by other event");

  a_fallen_clear_by_restart: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(fallen_r) && $past(rst_n) |-> $past(op_r) == OP_RESTART)
    else $error("fallen flag cleared by other event");

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");
`endif

endmodule

`default_nettype wire
